// ===== hdl/mp2_pkg.sv =====
// Shared types and constants for the 2-D max pooling stream unit.
package mp2_pkg;

    localparam int POOL_LIMIT  = 16;  // largest pool the bank mask can describe
    localparam int DIV_W       = 10;  // dividend width of the window classifier
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT  = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_POOL_ROWS     = 3'd3,
        REG_POOL_COLS     = 3'd4,
        REG_STRIDE_ROWS   = 3'd5,
        REG_STRIDE_COLS   = 3'd6
    } t_reg_index;

    // Clamped geometry as used by the datapath.
    typedef struct packed {
        logic [8:0] h;
        logic [8:0] w;
        logic [8:0] c;
        logic [4:0] pr;
        logic [4:0] pc;
        logic [3:0] sr;
        logic [3:0] sc;
    } t_geom;

    // One classified sample handed from front to back.
    typedef struct packed {
        logic signed [15:0]      sample;
        logic [7:0]              col;
        logic [3:0]              slot;
        logic                    wr_en;
        logic                    hit;
        logic [7:0]              c0;
        logic [POOL_LIMIT-1:0]   mask;
        logic [7:0]              ch;
        logic [7:0]              kr;
        logic [7:0]              kc;
        logic                    fdone;
    } t_task;

endpackage

// ===== hdl/mp2_queue.sv =====
// Two-entry queue between the classifier front and the pooling back end.
module mp2_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mp2_pkg::t_task i_task,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mp2_pkg::t_task o_task
);
    import mp2_pkg::*;

    t_task               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_task  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_task;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== hdl/mp2_front.sv =====
// Front end: accepts samples, tracks position, classifies window closings.
module mp2_front #(
    parameter int MAX_POOL = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mp2_pkg::t_geom      i_geom,
    input  logic                i_valid,
    input  logic signed [15:0]  i_sample,
    output logic                o_stall,
    output logic                o_push,
    output mp2_pkg::t_task      o_task,
    input  logic                i_full
);
    import mp2_pkg::*;

    localparam int PW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state             r_state;
    logic [3:0]         r_cnt;
    logic [7:0]         r_row, r_col, r_ch;
    logic [PW-1:0]      r_slot;
    logic signed [15:0] r_sample;
    logic [7:0]         r_trow, r_tcol, r_tch;
    logic [PW-1:0]      r_tslot;
    logic               r_inr;
    logic [DIV_W-1:0]   r_dv  [2];
    logic [DIV_W-1:0]   r_dvo [2];
    logic [3:0]         r_rem [2];
    logic [3:0]         r_s   [2];
    logic [4:0]         r_pe  [2];
    logic [8:0]         r_d   [2];
    logic [8:0]         r_xp1 [2];
    logic               r_edge[2];
    logic               r_ge  [2];

    logic               w_accept;
    logic [8:0]         w_x   [2];
    logic [8:0]         w_d   [2];
    logic [4:0]         w_p   [2];
    logic [3:0]         w_s   [2];
    logic [4:0]         w_pe  [2];
    logic [8:0]         w_xp1 [2];
    logic               w_edge[2];
    logic [DIV_W-1:0]   w_dv  [2];
    logic [4:0]         w_trial[2];
    logic               w_hit [2];
    logic               w_last[2];
    logic [DIV_W-1:0]   w_start[2];
    logic [8:0]         w_nr;
    logic [POOL_LIMIT-1:0] w_mask;
    t_task              w_task;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign o_push   = (r_state == S_PUSH) && !i_full;
    assign o_task   = w_task;

    assign w_x[0] = {1'b0, r_row};
    assign w_x[1] = {1'b0, r_col};
    assign w_d[0] = i_geom.h;
    assign w_d[1] = i_geom.w;
    assign w_p[0] = i_geom.pr;
    assign w_p[1] = i_geom.pc;
    assign w_s[0] = i_geom.sr;
    assign w_s[1] = i_geom.sc;

    // Per axis: the last column of a window is either a stride-aligned interior
    // point or the image edge, where only the final (possibly clipped) window ends.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_pe[a]   = ({4'b0, w_p[a]} > w_d[a]) ? w_d[a][4:0] : w_p[a];
            w_xp1[a]  = w_x[a] + 9'd1;
            w_edge[a] = (w_xp1[a] == w_d[a]);
            w_dv[a]   = w_edge[a] ?
                        ({1'b0, w_d[a]} + {6'b0, w_s[a]} - 10'd1 - {5'b0, w_pe[a]}) :
                        ({1'b0, w_xp1[a]} - {5'b0, w_pe[a]});
            w_trial[a] = {r_rem[a], r_dv[a][DIV_W-1]};
            w_hit[a]  = r_edge[a] ?
                        (({1'b0, r_s[a]} - 5'd1 - {1'b0, r_rem[a]}) < r_pe[a]) :
                        (r_ge[a] && (r_rem[a] == 4'd0));
            w_last[a] = r_edge[a] ||
                        (({1'b0, r_xp1[a]} - {5'b0, r_pe[a]} + {6'b0, r_s[a]})
                         >= {1'b0, r_d[a]});
            w_start[a] = r_dvo[a] - {6'b0, r_rem[a]};
        end
    end

    // Rows held in the line store: banks whose distance back from the current
    // slot is below the window height.
    always_comb begin
        logic [5:0] diff;
        w_nr   = {1'b0, r_trow} - w_start[0][8:0] + 9'd1;
        w_mask = '0;
        for (int b = 0; b < MAX_POOL; b++) begin
            if (6'(r_tslot) >= 6'(b)) diff = 6'(r_tslot) - 6'(b);
            else                      diff = 6'(r_tslot) + 6'(MAX_POOL) - 6'(b);
            w_mask[b] = ({3'b0, diff} < w_nr);
        end
    end

    always_comb begin
        w_task.sample = r_sample;
        w_task.col    = r_tcol;
        w_task.slot   = 4'(r_tslot);
        w_task.wr_en  = ({24'b0, r_tcol} < 32'(2**PW)) || (MAX_POOL > 0);
        w_task.hit    = r_inr && w_hit[0] && w_hit[1];
        w_task.c0     = w_start[1][7:0];
        w_task.mask   = w_mask;
        w_task.ch     = r_tch;
        w_task.kr     = r_dv[0][7:0];
        w_task.kc     = r_dv[1][7:0];
        w_task.fdone  = w_last[0] && w_last[1] && (({1'b0, r_tch} + 9'd1) == i_geom.c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ch    <= '0;
            r_slot  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sample <= i_sample;
                        r_trow   <= r_row;
                        r_tcol   <= r_col;
                        r_tch    <= r_ch;
                        r_tslot  <= r_slot;
                        r_inr    <= (w_x[0] < i_geom.h) && (w_x[1] < i_geom.w) &&
                                    ({1'b0, r_ch} < i_geom.c);
                        for (int a = 0; a < 2; a++) begin
                            r_dv[a]   <= w_dv[a];
                            r_dvo[a]  <= w_dv[a];
                            r_rem[a]  <= '0;
                            r_s[a]    <= w_s[a];
                            r_pe[a]   <= w_pe[a];
                            r_d[a]    <= w_d[a];
                            r_xp1[a]  <= w_xp1[a];
                            r_edge[a] <= w_edge[a];
                            r_ge[a]   <= (w_xp1[a] >= {4'b0, w_pe[a]});
                        end
                        r_cnt   <= 4'(DIV_W - 1);
                        r_state <= S_DIV;
                        if (w_xp1[1] >= i_geom.w) begin
                            r_col <= '0;
                            if (w_xp1[0] >= i_geom.h) begin
                                r_row  <= '0;
                                r_slot <= '0;
                                if (({1'b0, r_ch} + 9'd1) >= i_geom.c) r_ch <= '0;
                                else r_ch <= r_ch + 8'd1;
                            end else begin
                                r_row  <= r_row + 8'd1;
                                r_slot <= ({{(32-PW){1'b0}}, r_slot} == 32'(MAX_POOL - 1)) ?
                                          '0 : r_slot + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 8'd1;
                        end
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle on each axis
                    for (int a = 0; a < 2; a++) begin
                        if (w_trial[a] >= {1'b0, r_s[a]}) begin
                            r_rem[a] <= 4'(w_trial[a] - {1'b0, r_s[a]});
                            r_dv[a]  <= {r_dv[a][DIV_W-2:0], 1'b1};
                        end else begin
                            r_rem[a] <= w_trial[a][3:0];
                            r_dv[a]  <= {r_dv[a][DIV_W-2:0], 1'b0};
                        end
                    end
                    if (r_cnt == 4'd0) r_state <= S_PUSH;
                    else r_cnt <= r_cnt - 4'd1;
                end
                S_PUSH: begin
                    if (!i_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DIV) && (r_cnt == 4'(DIV_W - 1)))
        else $error("accepted sample did not start classification");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full && (r_state == S_PUSH))
        else $error("push into full queue");

    a_own_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && w_task.hit) |-> w_task.mask[r_tslot])
        else $error("closing window excludes current row bank");

endmodule

// ===== hdl/mp2_back.sv =====
// Back end: banked line store, window column scan and result register.
module mp2_back #(
    parameter int MAX_POOL  = 8,
    parameter int MAX_WIDTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  mp2_pkg::t_task     i_task,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_max_value,
    output logic [7:0]         o_out_channel,
    output logic [7:0]         o_out_row,
    output logic [7:0]         o_out_col,
    output logic               o_frame_done
);
    import mp2_pkg::*;

    localparam int PW = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN} t_state;

    logic signed [15:0] r_mem [MAX_POOL][MAX_WIDTH];
    logic signed [15:0] r_rd  [MAX_POOL];
    t_state             r_state;
    t_task              r_task;
    logic [7:0]         r_addr;
    logic               r_take;
    logic signed [15:0] r_best;

    logic               w_we;
    logic               w_re;
    logic [PW-1:0]      w_bank;
    logic [CW-1:0]      w_waddr;
    logic [CW-1:0]      w_raddr;
    logic signed [15:0] w_colmax;
    logic signed [15:0] w_newbest;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign w_we    = o_pop && i_task.wr_en && ({24'b0, i_task.col} < 32'(MAX_WIDTH));
    assign w_re    = (r_state == S_SCAN);
    assign w_bank  = i_task.slot[PW-1:0];
    assign w_waddr = CW'(i_task.col);
    assign w_raddr = CW'(r_addr);

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < MAX_POOL; b++) begin
            if (w_we && (w_bank == PW'(b))) r_mem[b][w_waddr] <= i_task.sample;
            if (w_re) r_rd[b] <= r_mem[b][w_raddr];
        end
    end

    always_comb begin
        w_colmax = 16'sh8000;
        for (int b = 0; b < MAX_POOL; b++) begin
            if (r_task.mask[b] && (r_rd[b] > w_colmax)) w_colmax = r_rd[b];
        end
        w_newbest = (w_colmax > r_best) ? w_colmax : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_take  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // in S_FIN the result register is reloaded below instead
            if (o_valid && !i_stall && (r_state != S_FIN)) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_task <= i_task;
                        if (i_task.hit) begin
                            r_addr  <= i_task.c0;
                            r_best  <= 16'sh8000;
                            r_take  <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_take <= 1'b1;
                    if (r_take) r_best <= w_newbest;
                    if (r_addr == r_task.col) r_state <= S_DRAIN;
                    else r_addr <= r_addr + 8'd1;
                end
                S_DRAIN: begin
                    r_best  <= w_newbest;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!o_valid || !i_stall) begin
                        o_valid       <= 1'b1;
                        o_max_value   <= r_best;
                        o_out_channel <= r_task.ch;
                        o_out_row     <= r_task.kr;
                        o_out_col     <= r_task.kc;
                        o_frame_done  <= r_task.fdone;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty && (r_state == S_IDLE))
        else $error("pop outside idle or from empty queue");

    a_scan_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_task.hit && (r_addr <= r_task.col))
        else $error("column scan out of window");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !o_valid) |=> o_valid && (r_state == S_IDLE))
        else $error("free result register not loaded");

endmodule

// ===== hdl/max_pool_2d_stream_unit.sv =====
// Top level of the 2-D max pooling stream unit: config registers and wiring.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_sample
//  output  | out       | o_valid / i_stall  | o_max_value, o_out_channel, o_out_row,
//          |           |                    | o_out_col, o_frame_done
//  config  | in        | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// In the front a sample passes one accept step, 10 classifier division steps
// and one queue push, which waits while the queue is full. A sample that
// closes a window then passes through the back: one line store write, one
// read per window column across all row banks, one drain and one result load.
// Reset is synchronous; it clears positions and control, not the line store.
// A stalled output holds its result; the queue keeps the front working until full.
module max_pool_2d_stream_unit #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_POOL     = 8,
    parameter int MAX_CHANNELS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_max_value,
    output logic [7:0]         o_out_channel,
    output logic [7:0]         o_out_row,
    output logic [7:0]         o_out_col,
    output logic               o_frame_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mp2_pkg::*;

    localparam int WLIM = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int CLIM = (MAX_CHANNELS < 256) ? MAX_CHANNELS : 256;

    logic [8:0] r_image_height, r_image_width, r_channel_count;
    logic [3:0] r_pool_rows, r_pool_cols, r_stride_rows, r_stride_cols;

    t_reg_index w_idx;
    t_geom      w_geom;
    t_task      w_ftask, w_btask;
    logic       w_push, w_full, w_pop, w_empty;

    assign pready = 1'b1;
    assign w_idx  = t_reg_index'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_height  <= 9'd1;
            r_image_width   <= 9'd1;
            r_channel_count <= 9'd1;
            r_pool_rows     <= 4'd2;
            r_pool_cols     <= 4'd2;
            r_stride_rows   <= 4'd2;
            r_stride_cols   <= 4'd2;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[8:0];
                REG_IMAGE_WIDTH:   r_image_width   <= pwdata[8:0];
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[8:0];
                REG_POOL_ROWS:     r_pool_rows     <= pwdata[3:0];
                REG_POOL_COLS:     r_pool_cols     <= pwdata[3:0];
                REG_STRIDE_ROWS:   r_stride_rows   <= pwdata[3:0];
                REG_STRIDE_COLS:   r_stride_cols   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_IMAGE_HEIGHT:  prdata = {23'b0, r_image_height};
            REG_IMAGE_WIDTH:   prdata = {23'b0, r_image_width};
            REG_CHANNEL_COUNT: prdata = {23'b0, r_channel_count};
            REG_POOL_ROWS:     prdata = {28'b0, r_pool_rows};
            REG_POOL_COLS:     prdata = {28'b0, r_pool_cols};
            REG_STRIDE_ROWS:   prdata = {28'b0, r_stride_rows};
            REG_STRIDE_COLS:   prdata = {28'b0, r_stride_cols};
            default:           prdata = '0;
        endcase
    end

    // zero means one; dimensions saturate, pools saturate at MAX_POOL
    always_comb begin
        w_geom.h  = (r_image_height == '0) ? 9'd1 :
                    (r_image_height > 9'd256) ? 9'd256 : r_image_height;
        w_geom.w  = (r_image_width == '0) ? 9'd1 :
                    (r_image_width > 9'(WLIM)) ? 9'(WLIM) : r_image_width;
        w_geom.c  = (r_channel_count == '0) ? 9'd1 :
                    (r_channel_count > 9'(CLIM)) ? 9'(CLIM) : r_channel_count;
        w_geom.pr = (r_pool_rows == '0) ? 5'd1 :
                    ({1'b0, r_pool_rows} > 5'(MAX_POOL)) ? 5'(MAX_POOL) : {1'b0, r_pool_rows};
        w_geom.pc = (r_pool_cols == '0) ? 5'd1 :
                    ({1'b0, r_pool_cols} > 5'(MAX_POOL)) ? 5'(MAX_POOL) : {1'b0, r_pool_cols};
        w_geom.sr = (r_stride_rows == '0) ? 4'd1 : r_stride_rows;
        w_geom.sc = (r_stride_cols == '0) ? 4'd1 : r_stride_cols;
    end

    mp2_front #(.MAX_POOL(MAX_POOL)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (w_geom),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_task   (w_ftask),
        .i_full   (w_full)
    );

    mp2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_task  (w_ftask),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_task  (w_btask)
    );

    mp2_back #(.MAX_POOL(MAX_POOL), .MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_task        (w_btask),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_max_value   (o_max_value),
        .o_out_channel (o_out_channel),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_frame_done  (o_frame_done)
    );

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the 2-D max pooling stream unit: predictor, scoreboard and stimulus.
module tb_top;
    import mp2_pkg::*;

    localparam int LINE_W     = 256;
    localparam int LINE_P     = 8;
    localparam int N_ITEMS    = 1750;
    localparam int TAIL_ITEMS = 512;
    localparam int MAX_CYC    = 1500000;

    typedef struct packed {
        logic signed [15:0] max_value;
        logic [7:0]         ch;
        logic [7:0]         row;
        logic [7:0]         col;
        logic               fdone;
    } t_pool_out;

    // Pooling predictor plus queue of pending window maxima.
    class pool_scoreboard;
        logic [8:0] height, width, chans;
        logic [3:0] prow, pcol, srow, scol;
        logic [15:0] lines [LINE_P*LINE_W];
        int unsigned rpos, cpos, chpos;
        t_pool_out pending[$];
        int errors, checked;

        function new();
            height = 1; width = 1; chans = 1;
            prow = 2; pcol = 2; srow = 2; scol = 2;
            rpos = 0; cpos = 0; chpos = 0;
            errors = 0; checked = 0;
            foreach (lines[i]) lines[i] = '0;
        endfunction

        function void set_reg(t_reg_index idx, logic [31:0] v);
            case (idx)
                REG_IMAGE_HEIGHT:  height = v[8:0];
                REG_IMAGE_WIDTH:   width = v[8:0];
                REG_CHANNEL_COUNT: chans = v[8:0];
                REG_POOL_ROWS:     prow = v[3:0];
                REG_POOL_COLS:     pcol = v[3:0];
                REG_STRIDE_ROWS:   srow = v[3:0];
                default:           scol = v[3:0];
            endcase
        endfunction

        static function int unsigned clampv(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        // Window on one axis that ends at x; returns hit, index and last flag.
        static function bit win_end(int unsigned x, int unsigned d, int unsigned p,
                                    int unsigned s, output int unsigned k,
                                    output bit last);
            int unsigned n, lastk, e;
            bit hit;
            hit = 0; k = 0; lastk = 0;
            if (p > d) p = d;
            n = (d - p + s - 1) / s + 1;
            for (int unsigned i = 0; i < n && i * s < d; i++) begin
                e = i * s + p;
                if (e > d) e = d;
                if (e - 1 == x) begin
                    hit = 1;
                    k = i;
                end
                lastk = i;
            end
            last = hit && (k == lastk);
            return hit;
        endfunction

        function void note_sample(logic signed [15:0] smp);
            int unsigned h, w, c, pr, pc, sr, sc, kr, kc;
            bit lr, lc;
            logic signed [15:0] best, v;
            t_pool_out res;
            h = clampv(height, 256); w = clampv(width, LINE_W);
            c = clampv(chans, 256);
            pr = clampv(prow, LINE_P); pc = clampv(pcol, LINE_P);
            sr = (srow != 0) ? srow : 1; sc = (scol != 0) ? scol : 1;
            if (cpos < LINE_W) lines[(rpos % LINE_P) * LINE_W + cpos] = smp;
            if (rpos < h && cpos < w && chpos < c &&
                win_end(rpos, h, pr, sr, kr, lr) && win_end(cpos, w, pc, sc, kc, lc)) begin
                best = lines[(rpos % LINE_P) * LINE_W + cpos];
                for (int unsigned r = kr * sr; r <= rpos; r++)
                    for (int unsigned q = kc * sc; q <= cpos; q++) begin
                        v = lines[(r % LINE_P) * LINE_W + q];
                        if (v > best) best = v;
                    end
                res.max_value = best;
                res.ch = chpos[7:0]; res.row = kr[7:0]; res.col = kc[7:0];
                res.fdone = lr && lc && (chpos + 1 == c);
                pending.push_back(res);
            end
            cpos++;
            if (cpos >= w) begin
                cpos = 0;
                rpos++;
                if (rpos >= h) begin
                    rpos = 0;
                    chpos++;
                    if (chpos >= c) chpos = 0;
                end
            end
            cpos &= 8'hff; rpos &= 8'hff; chpos &= 8'hff;
        endfunction

        function void check_result(t_pool_out got);
            t_pool_out exp;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected val=%0d ch=%0d row=%0d col=%0d fd=%0b,",
                              " got val=%0d ch=%0d row=%0d col=%0d fd=%0b"},
                             exp.max_value, exp.ch, exp.row, exp.col, exp.fdone,
                             got.max_value, got.ch, got.row, got.col, got.fdone);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_stall, psel, penable, pwrite;
    logic signed [15:0] i_sample;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic o_stall, o_valid, o_frame_done, pready;
    logic signed [15:0] o_max_value;
    logic [7:0] o_out_channel, o_out_row, o_out_col;
    logic [31:0] prdata;

    pool_scoreboard pool_sb;
    bit quiet;          // no idling on either side
    int unsigned cycles, fed;

    max_pool_2d_stream_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver side: random stall, check each transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            pool_sb.check_result({o_max_value, o_out_channel, o_out_row, o_out_col,
                                  o_frame_done});
        i_stall <= !i_rst_n ? 1'b0 : (!quiet && $urandom_range(99) < 10);
    end

    task automatic write_reg(t_reg_index idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        pool_sb.set_reg(idx, v);
    endtask

    task automatic set_geom(int h, int w, int c, int pr, int pc, int sr, int sc);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_CHANNEL_COUNT, c);
        write_reg(REG_POOL_ROWS, pr);
        write_reg(REG_POOL_COLS, pc);
        write_reg(REG_STRIDE_ROWS, sr);
        write_reg(REG_STRIDE_COLS, sc);
    endtask

    task automatic send_sample(logic signed [15:0] s);
        while (!quiet && $urandom_range(99) < 10) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pool_sb.note_sample(s);
        fed++;
    endtask

    task automatic wait_drain();
        i_valid <= 0;
        while (pool_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);   // samples with no window may still be in flight
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // Full frames only, so the line store is never read before being written.
    task automatic run_frame(int h, int w, int c);
        for (int i = 0; i < h * w * c; i++) send_sample(rand_sample());
    endtask

    int h, w, c;

    initial begin
        pool_sb = new();
        quiet = 0; cycles = 0; fed = 0;
        i_rst_n = 0; i_valid = 0; i_sample = 0; i_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset geometry: 1x1x1 image, pool clamped to the image.
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        wait_drain();
        // 3x5, pool 2x2 stride 2: windows clipped at the right and bottom.
        set_geom(3, 5, 1, 2, 2, 2, 2);
        for (int i = 0; i < 15; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7fff);
        wait_drain();
        // Zero registers treated as 1, oversized pool saturates.
        set_geom(0, 2, 0, 0, 15, 0, 0);
        run_frame(1, 2, 1);
        wait_drain();
        // Stride larger than pool: some samples close no window.
        set_geom(2, 4, 2, 1, 1, 8, 3);
        run_frame(2, 4, 2);
        wait_drain();

        // Random well-formed frames; one full-width frame for the extremes.
        set_geom(1, 256, 2, 8, 8, 8, 8);
        run_frame(1, 256, 2);
        wait_drain();
        while (fed < N_ITEMS - TAIL_ITEMS) begin
            quiet = ($urandom_range(9) == 0);
            h = $urandom_range(1, 10); w = $urandom_range(1, 12); c = $urandom_range(1, 3);
            set_geom(h, w, c, $urandom_range(15), $urandom_range(15),
                     $urandom_range(15), $urandom_range(15));
            run_frame(h, w, c);
            wait_drain();
        end
        // Large height and channel count with a tiny width.
        set_geom(256, 1, 1, 8, 1, 1, 1);
        run_frame(256, 1, 1);
        wait_drain();
        set_geom(1, 1, 256, 1, 1, 1, 1);
        run_frame(1, 1, 256);
        wait_drain();

        $display("Streamed %0d samples through random frame geometries, pools and strides;",
                 fed);
        $display("%0d pooled results checked with random stalls on both sides.",
                 pool_sb.checked);
        if (pool_sb.errors == 0 && pool_sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d errors, %0d results missing", pool_sb.errors,
                     pool_sb.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
